@@ src/mfp_pkg.sv @@
// Message frame parser: shared constants, role and status codes, and the
// frame state and result structures.
// No dependencies; every other file of the block imports this package.
package mfp_pkg;

	// Largest frame in bytes; the byte counter saturates at 16 bits
	localparam longint unsigned MAX_FRAME_BYTES = 65535;
	localparam logic [15:0] FRAME_LIMIT =
		(MAX_FRAME_BYTES < 65535) ? 16'(MAX_FRAME_BYTES) : 16'hFFFF;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Reset value of the name length limit register
	localparam logic [7:0] NAME_LIMIT_RESET = 8'd36;

	// Header layout
	localparam logic [15:0] ID_BYTES       = 16'd8;
	localparam logic [15:0] FLAG_INDEX     = 16'd8;
	localparam logic [15:0] NAMELEN_INDEX  = 16'd9;
	localparam logic [15:0] TAG_START      = 16'd10;
	localparam logic [15:0] TAG_END        = 16'd18;
	localparam logic [5:0]  BODY_PLAIN     = 6'd10;
	localparam logic [5:0]  BODY_TAGGED    = 6'd18;
	localparam logic [5:0]  AUTH_BYTES     = 6'd16;
	localparam logic [5:0]  CRYPT_HDR      = 6'd28;
	localparam logic [5:0]  SIG_BYTES      = 6'd32;

	// Flag byte bits
	localparam int FLAG_ENCRYPTED = 7;
	localparam int FLAG_HAS_TAG   = 3;

	// Byte roles
	localparam logic [3:0] ROLE_ID      = 4'd0;
	localparam logic [3:0] ROLE_FLAG    = 4'd1;
	localparam logic [3:0] ROLE_NAMELEN = 4'd2;
	localparam logic [3:0] ROLE_TAG     = 4'd3;
	localparam logic [3:0] ROLE_AUTHTAG = 4'd4;
	localparam logic [3:0] ROLE_IV      = 4'd5;
	localparam logic [3:0] ROLE_SIG     = 4'd6;
	localparam logic [3:0] ROLE_NAME    = 4'd7;
	localparam logic [3:0] ROLE_DATA    = 4'd8;

	// Frame status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_BAD_NAME  = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	// Per-frame state
	typedef struct packed {
		logic [15:0] byte_count;
		logic [7:0]  flags;
		logic [7:0]  name_len;
		logic [63:0] id;
		logic [63:0] tag;
		logic        overflow;
	} frame_state_t;

	// One labelled byte with the frame summary
	typedef struct packed {
		logic [7:0]  byte_value;
		logic [3:0]  byte_role;
		logic [15:0] role_offset;
		logic        frame_done;
		logic [1:0]  status;
		logic [63:0] message_id;
		logic [63:0] message_tag;
		logic [2:0]  message_type;
		logic [3:0]  frame_flags;
		logic [7:0]  name_length;
		logic [15:0] data_length;
	} result_t;

endpackage

@@ src/mfp_state.sv @@
// Message frame parser: per-frame state registers and the name length
// limit register. Depends on mfp_pkg.
module mfp_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 frame_end,
	input  mfp_pkg::frame_state_t state_next,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	output mfp_pkg::frame_state_t state,
	output logic [7:0]           name_limit
);
	import mfp_pkg::*;

	frame_state_t state_q;
	logic [7:0]   name_limit_q;

	// Frame state: load the updated state, or clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				state_q <= '0;
			end else begin
				state_q <= state_next;
			end
		end
	end

	// Name length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q <= NAME_LIMIT_RESET;
		end else if (cfg_we) begin
			name_limit_q <= cfg_wdata;
		end
	end

	assign state      = state_q;
	assign name_limit = name_limit_q;

endmodule

@@ src/mfp_decode.sv @@
// Message frame parser: labels one byte with role and offset, builds the
// updated frame state and, on the final byte, the summary and status.
// Depends on mfp_pkg.
module mfp_decode (
	input  logic                 [7:0] frame_byte,
	input  logic                       final_byte,
	input  mfp_pkg::frame_state_t      state,
	input  logic                 [7:0] name_limit,
	output mfp_pkg::frame_state_t      state_next,
	output mfp_pkg::result_t           result
);
	import mfp_pkg::*;

	logic [15:0] idx;
	logic [7:0]  flags_n;
	logic [7:0]  nl_n;
	logic [63:0] id_n;
	logic [63:0] tag_n;
	logic        ovf_n;
	logic [2:0]  tag_lane;
	logic [5:0]  body;
	logic [5:0]  name_start;
	logic [8:0]  name_end;
	logic [16:0] len;
	logic        short_hdr;
	logic        bad_name;
	logic        short_name;
	logic [1:0]  status;
	logic [3:0]  role;
	logic [15:0] offset;

	assign idx = state.byte_count;

	// Header capture
	assign tag_lane = idx[2:0] - 3'd2;
	assign flags_n  = (idx == FLAG_INDEX) ? frame_byte : state.flags;
	assign nl_n     = (idx == NAMELEN_INDEX) ? frame_byte : state.name_len;
	assign id_n     = (idx < ID_BYTES)
		? (state.id | ({56'd0, frame_byte} << {idx[2:0], 3'b000})) : state.id;
	assign tag_n    = (state.flags[FLAG_HAS_TAG] && idx >= TAG_START && idx < TAG_END)
		? (state.tag | ({56'd0, frame_byte} << {tag_lane, 3'b000})) : state.tag;
	assign ovf_n    = state.overflow | (idx >= FRAME_LIMIT);

	assign state_next.byte_count = (idx == COUNT_MAX) ? idx : idx + 16'd1;
	assign state_next.flags      = flags_n;
	assign state_next.name_len   = nl_n;
	assign state_next.id         = id_n;
	assign state_next.tag        = tag_n;
	assign state_next.overflow   = ovf_n;

	// Section boundaries
	assign body       = flags_n[FLAG_HAS_TAG] ? BODY_TAGGED : BODY_PLAIN;
	assign name_start = body + (flags_n[FLAG_ENCRYPTED] ? CRYPT_HDR : SIG_BYTES);
	assign name_end   = {3'd0, name_start} + {1'b0, nl_n};

	// Role and offset within the role
	always_comb begin
		priority if (idx < ID_BYTES) begin
			role   = ROLE_ID;
			offset = idx;
		end else if (idx == FLAG_INDEX) begin
			role   = ROLE_FLAG;
			offset = '0;
		end else if (idx == NAMELEN_INDEX) begin
			role   = ROLE_NAMELEN;
			offset = '0;
		end else if (idx < {10'd0, body}) begin
			role   = ROLE_TAG;
			offset = idx - TAG_START;
		end else if (flags_n[FLAG_ENCRYPTED] && idx < {10'd0, body + AUTH_BYTES}) begin
			role   = ROLE_AUTHTAG;
			offset = idx - {10'd0, body};
		end else if (flags_n[FLAG_ENCRYPTED] && idx < {10'd0, name_start}) begin
			role   = ROLE_IV;
			offset = idx - {10'd0, body + AUTH_BYTES};
		end else if (idx < {10'd0, name_start}) begin
			role   = ROLE_SIG;
			offset = idx - {10'd0, body};
		end else if (idx < {7'd0, name_end}) begin
			role   = ROLE_NAME;
			offset = idx - {10'd0, name_start};
		end else begin
			role   = ROLE_DATA;
			offset = idx - {7'd0, name_end};
		end
	end

	// Frame status, checked in priority order
	assign len        = {1'b0, idx} + 17'd1;
	assign short_hdr  = (len < 17'd10) || (flags_n[FLAG_HAS_TAG] && len < 17'd18);
	assign bad_name   = (nl_n == 8'd0) || (nl_n > name_limit);
	assign short_name = len < {8'd0, name_end};

	always_comb begin
		priority if (ovf_n) begin
			status = ST_TOO_LONG;
		end else if (short_hdr) begin
			status = ST_SHORT;
		end else if (bad_name) begin
			status = ST_BAD_NAME;
		end else if (short_name) begin
			status = ST_SHORT;
		end else begin
			status = ST_OK;
		end
	end

	// Result; summary fields only on the final byte
	always_comb begin
		result             = '0;
		result.byte_value  = frame_byte;
		result.byte_role   = role;
		result.role_offset = offset;
		if (final_byte) begin
			result.frame_done   = 1'b1;
			result.status       = status;
			result.message_id   = id_n;
			result.message_tag  = flags_n[FLAG_HAS_TAG] ? tag_n : 64'd0;
			result.message_type = flags_n[2:0];
			result.frame_flags  = flags_n[7:4];
			result.name_length  = nl_n;
			result.data_length  = (status == ST_OK)
				? 16'(len - {8'd0, name_end}) : 16'd0;
		end
	end

endmodule

@@ src/message_frame_parser_top.sv @@
// Message frame parser top level: input register, decode, output register.
// Depends on mfp_pkg, mfp_state and mfp_decode.
//
// Usage:
//   Frame bytes enter on the s_ stream, one byte per transaction in
//   s_tdata, with s_tlast high on the final byte of a frame. Each byte
//   leaves on the m_ stream as one transaction: s_tdata passed through,
//   its role in m_tuser, its offset in m_tdata, and m_tlast high on the
//   final byte, where m_tdata also carries the header summary, the data
//   length and the status. On other bytes the summary fields are zero.
//   cfg_we/cfg_wdata write the largest accepted name length; write it
//   only while no frame is in flight.
// Pipeline: each byte passes the input register, then the result
//   register. Throughput: one byte per cycle while m_tready is high; the
//   frame state update is the only loop.
// Reset: the frame state clears and the name limit returns to 36; no
//   transaction is held. The frame state clears again after each final byte.
// Stall: when m_tready is low the result is held and one more byte is
//   kept in the input register; s_tready then drops.
module message_frame_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: name length limit
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] frame_byte
	input  logic         s_tlast,   // final_byte
	// Result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] byte_value, [23:8] role_offset, [25:24] status,
	// [89:26] message_id, [153:90] message_tag, [156:154] message_type,
	// [160:157] frame_flags, [168:161] name_length, [184:169] data_length,
	// [191:185] zero
	output logic [191:0] m_tdata,
	output logic [3:0]   m_tuser,   // [3:0] byte_role
	output logic         m_tlast    // frame_done
);
	import mfp_pkg::*;

	logic         in_valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_valid_s2;
	result_t      res_s2;
	logic         out_free;
	logic         advance;
	frame_state_t state;
	frame_state_t state_next;
	logic [7:0]   name_limit;
	result_t      result;

	assign out_free = !out_valid_s2 || m_tready;
	assign advance  = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mfp_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.frame_end  (last_s1),
		.state_next (state_next),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.state      (state),
		.name_limit (name_limit)
	);

	mfp_decode u_decode (
		.frame_byte (byte_s1),
		.final_byte (last_s1),
		.state      (state),
		.name_limit (name_limit),
		.state_next (state_next),
		.result     (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	// Output packing
	assign m_tvalid = out_valid_s2;
	assign m_tuser  = res_s2.byte_role;
	assign m_tlast  = res_s2.frame_done;
	assign m_tdata  = {7'd0,
		res_s2.data_length,
		res_s2.name_length,
		res_s2.frame_flags,
		res_s2.message_type,
		res_s2.message_tag,
		res_s2.message_id,
		res_s2.status,
		res_s2.role_offset,
		res_s2.byte_value};

endmodule
